@@ rtl/q4_block_dot_product_assert.svh @@
// assertion macros for the block dot product
`ifndef Q4_BLOCK_DOT_PRODUCT_ASSERT_SVH
`define Q4_BLOCK_DOT_PRODUCT_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is high
`define Q4BDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also covers the reset cycles
`define Q4BDP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define Q4BDP_ASSERT(lbl, prop, msg)
`define Q4BDP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ rtl/q4bdp_pkg.sv @@
`timescale 1ns / 1ps

package q4bdp_pkg;

  localparam int BLOCK_VALUES  = 32;
  localparam int NIBBLE_OFFSET = 8;
  localparam int LANES         = 4;
  localparam int BLOCK_BYTES   = BLOCK_VALUES / 2;
  localparam int LANE_BYTES    = BLOCK_BYTES / LANES;
  localparam int LANE_BITS     = LANE_BYTES * 8;
  localparam int BLOCK_BITS    = BLOCK_BYTES * 8;
  localparam int LANE_SUM_W    = 11;
  localparam int BLOCK_SUM_W   = 13;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  // operand pair handed to a floating point unit
  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
  } fp_req_t;

  // result coming back from a floating point unit
  typedef struct packed {
    logic        valid;
    logic [31:0] res;
  } fp_rsp_t;

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  // round to nearest even and pack; m has its leading one at bit 26,
  // be is the biased exponent of that leading one
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [9:0] be,
                                             input logic [26:0] m);
    logic [4:0]  sh;
    logic [26:0] mask;
    logic [26:0] m2;
    logic        stk;
    logic        inc;
    logic [7:0]  ef;
    logic [30:0] mag;
    if (be >= 10'sd1) begin
      sh = 5'd0;
    end else if (be <= -10'sd26) begin
      sh = 5'd27;
    end else begin
      sh = 5'(10'sd1 - be);
    end
    mask = ~(27'h7FF_FFFF << sh);
    m2   = m >> sh;
    stk  = |(m & mask);
    ef   = (be >= 10'sd1) ? be[7:0] : 8'd0;
    inc  = m2[2] & (m2[1] | m2[0] | stk | m2[3]);
    mag  = {ef, m2[25:3]} + 31'(inc);
    if (be >= 10'sd255) begin
      return {sign, INF_MAG};
    end
    return {sign, mag};
  endfunction

endpackage

@@ rtl/q4bdp_ifs.sv @@
`timescale 1ns / 1ps

// block pair channel
interface q4bdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] scale_a;
  logic [31:0] scale_b;
  logic [63:0] nibbles_a_low;
  logic [63:0] nibbles_a_high;
  logic [63:0] nibbles_b_low;
  logic [63:0] nibbles_b_high;
  logic        is_last;

  modport source (output valid, scale_a, scale_b, nibbles_a_low, nibbles_a_high,
                  nibbles_b_low, nibbles_b_high, is_last, input ready);
  modport sink (input valid, scale_a, scale_b, nibbles_a_low, nibbles_a_high,
                nibbles_b_low, nibbles_b_high, is_last, output ready);
endinterface

// result channel
interface q4bdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result;

  modport source (output valid, dot_result, input ready);
  modport sink (input valid, dot_result, output ready);
endinterface

@@ rtl/q4bdp_lane.sv @@
`timescale 1ns / 1ps

module q4bdp_lane
  import q4bdp_pkg::*;
(
  input  logic                         clk,
  input  logic                         load,
  input  logic [LANE_BITS-1:0]         a,
  input  logic [LANE_BITS-1:0]         b,
  output logic signed [LANE_SUM_W-1:0] sum
);

  logic signed [LANE_SUM_W-1:0] sum_next;

  // offset each nibble pair, multiply, add up the lane
  always_comb begin
    logic signed [4:0] da;
    logic signed [4:0] db;
    logic signed [9:0] prod;
    sum_next = '0;
    for (int i = 0; i < 2 * LANE_BYTES; i++) begin
      da = $signed({1'b0, a[4*i +: 4]}) - 5'(NIBBLE_OFFSET);
      db = $signed({1'b0, b[4*i +: 4]}) - 5'(NIBBLE_OFFSET);
      prod = da * db;
      sum_next = sum_next + LANE_SUM_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

endmodule

@@ rtl/q4bdp_fmul.sv @@
`timescale 1ns / 1ps

module q4bdp_fmul
  import q4bdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  // stage 1: raw mantissa product
  logic               v1, v2, v3;
  logic [47:0]        prod;
  logic signed [9:0]  e1;
  logic               s1, nan1, inf1;
  // stage 2: normalized product
  logic [47:0]        pn;
  logic signed [9:0]  e2;
  logic               s2, nan2, inf2, zero2;
  // stage 3: packed result
  logic [31:0]        res3;

  always_comb begin
    rsp.valid = v3;
    rsp.res   = res3;
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // unpack and multiply
  always_ff @(posedge clk) begin
    logic [23:0] ma, mb;
    logic [7:0]  ea, eb;
    logic        za, zb;
    if (req.valid) begin
      ma   = {req.a[30:23] != 8'd0, req.a[22:0]};
      mb   = {req.b[30:23] != 8'd0, req.b[22:0]};
      ea   = (req.a[30:23] == 8'd0) ? 8'd1 : req.a[30:23];
      eb   = (req.b[30:23] == 8'd0) ? 8'd1 : req.b[30:23];
      za   = req.a[30:0] == 31'd0;
      zb   = req.b[30:0] == 31'd0;
      prod <= ma * mb;
      e1   <= $signed({2'b0, ea}) + $signed({2'b0, eb}) - 10'sd126;
      s1   <= req.a[31] ^ req.b[31];
      nan1 <= is_nan(req.a) || is_nan(req.b) || (is_inf(req.a) && zb)
              || (is_inf(req.b) && za);
      inf1 <= is_inf(req.a) || is_inf(req.b);
    end
  end

  // leading one search and normalizing shift
  always_ff @(posedge clk) begin
    logic [5:0] lz;
    lz = 6'd47;
    for (int i = 0; i < 48; i++) begin
      if (prod[i]) begin
        lz = 6'(47 - i);
      end
    end
    if (v1) begin
      pn    <= prod << lz;
      e2    <= e1 - $signed({4'b0, lz});
      s2    <= s1;
      nan2  <= nan1;
      inf2  <= inf1;
      zero2 <= prod == 48'd0;
    end
  end

  // round and pack
  always_ff @(posedge clk) begin
    if (v2) begin
      priority if (nan2) begin
        res3 <= CANON_NAN;
      end else if (inf2) begin
        res3 <= {s2, INF_MAG};
      end else if (zero2) begin
        res3 <= {s2, 31'd0};
      end else begin
        res3 <= round_pack(s2, e2, {pn[47:22], |pn[21:0]});
      end
    end
  end

endmodule

@@ rtl/q4bdp_fadd.sv @@
`timescale 1ns / 1ps

module q4bdp_fadd
  import q4bdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  fp_req_t req,
  output fp_rsp_t rsp
);

  // stage 1: aligned sum
  logic              v1, v2, v3;
  logic [27:0]       s1;
  logic [7:0]        ex1;
  logic              sg1, nan1, inf1, isg1, bz1, zs1;
  // stage 2: normalized sum
  logic [26:0]       m2;
  logic signed [9:0] e2;
  logic              sg2, nan2, inf2, isg2, bz2, zs2, zero2;
  // stage 3: packed result
  logic [31:0]       res3;

  always_comb begin
    rsp.valid = v3;
    rsp.res   = res3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // order by magnitude, align the smaller operand, add or subtract
  always_ff @(posedge clk) begin
    logic [31:0] x, y;
    logic [7:0]  ex, ey, d;
    logic [26:0] xa, yb, ys, mask;
    logic        st;
    if (req.valid) begin
      if (req.b[30:0] > req.a[30:0]) begin
        x = req.b;
        y = req.a;
      end else begin
        x = req.a;
        y = req.b;
      end
      ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
      ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
      d  = ex - ey;
      xa = {x[30:23] != 8'd0, x[22:0], 3'b000};
      yb = {y[30:23] != 8'd0, y[22:0], 3'b000};
      if (d >= 8'd27) begin
        ys = {26'd0, yb != 27'd0};
      end else begin
        mask = ~(27'h7FF_FFFF << d[4:0]);
        st   = |(yb & mask);
        ys   = yb >> d[4:0];
        ys   = {ys[26:1], ys[0] | st};
      end
      if (x[31] ^ y[31]) begin
        s1 <= {1'b0, xa} - {1'b0, ys};
      end else begin
        s1 <= {1'b0, xa} + {1'b0, ys};
      end
      ex1  <= ex;
      sg1  <= x[31];
      nan1 <= is_nan(req.a) || is_nan(req.b)
              || (is_inf(req.a) && is_inf(req.b) && (req.a[31] != req.b[31]));
      inf1 <= is_inf(req.a) || is_inf(req.b);
      isg1 <= is_inf(req.a) ? req.a[31] : req.b[31];
      bz1  <= (req.a[30:0] == 31'd0) && (req.b[30:0] == 31'd0);
      zs1  <= req.a[31] & req.b[31];
    end
  end

  // normalize: carry out shifts right, cancellation shifts left
  always_ff @(posedge clk) begin
    logic [4:0] lz;
    lz = 5'd26;
    for (int i = 0; i < 27; i++) begin
      if (s1[i]) begin
        lz = 5'(26 - i);
      end
    end
    if (v1) begin
      if (s1[27]) begin
        m2 <= {s1[27:2], |s1[1:0]};
        e2 <= $signed({2'b0, ex1}) + 10'sd1;
      end else begin
        m2 <= s1[26:0] << lz;
        e2 <= $signed({2'b0, ex1}) - $signed({5'b0, lz});
      end
      sg2   <= sg1;
      nan2  <= nan1;
      inf2  <= inf1;
      isg2  <= isg1;
      bz2   <= bz1;
      zs2   <= zs1;
      zero2 <= s1 == 28'd0;
    end
  end

  // round and pack; exact cancellation gives plus zero
  always_ff @(posedge clk) begin
    if (v2) begin
      priority if (nan2) begin
        res3 <= CANON_NAN;
      end else if (inf2) begin
        res3 <= {isg2, INF_MAG};
      end else if (zero2) begin
        res3 <= {bz2 & zs2, 31'd0};
      end else begin
        res3 <= round_pack(sg2, e2, m2);
      end
    end
  end

endmodule

@@ rtl/q4_block_dot_product.sv @@
// channel  dir  handshake     payload
// blocks   in   valid/ready   scale_a, scale_b, nibbles_{a,b}_{low,high}, is_last
// result   out  valid/ready   dot_result (only after an item with is_last)
//
// one item at a time: an item holds the block while it passes the chain
// of scale multiply, block term multiply and accumulator add units plus
// the state update; the accumulator and any result change when the add
// delivers its sum, or once a stalled result is taken. the four nibble
// lanes and the merge run alongside the scale multiply.
// reset clears the accumulator to plus zero and drops any pending result.
// a finished result waits in the output register; a second one stalls
// the block until the first is taken.
`timescale 1ns / 1ps

`include "q4_block_dot_product_assert.svh"

module q4_block_dot_product
  import q4bdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  q4bdp_in_if.sink     blocks,
  q4bdp_out_if.source  result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                        state;
  logic                          accept;
  logic                          last_r;
  logic [31:0]                   acc;
  logic                          out_v;
  logic [31:0]                   out_data;
  logic                          can_emit;
  logic                          out_load;
  logic [BLOCK_BITS-1:0]         nib_a, nib_b;
  logic signed [LANE_SUM_W-1:0]  lane_sum [LANES];
  logic signed [BLOCK_SUM_W-1:0] block_sum;
  logic [31:0]                   isum_f;
  fp_req_t                       m1_req, m2_req, add_req;
  fp_rsp_t                       m1_rsp, m2_rsp, add_rsp;

  assign blocks.ready      = state == S_IDLE;
  assign accept            = blocks.valid & blocks.ready;
  assign result.valid      = out_v;
  assign result.dot_result = out_data;
  assign can_emit          = !out_v || result.ready;
  assign nib_a             = {blocks.nibbles_a_high, blocks.nibbles_a_low};
  assign nib_b             = {blocks.nibbles_b_high, blocks.nibbles_b_low};

  // nibble lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q4bdp_lane u_lane (
      .clk  (clk),
      .load (accept),
      .a    (nib_a[g*LANE_BITS +: LANE_BITS]),
      .b    (nib_b[g*LANE_BITS +: LANE_BITS]),
      .sum  (lane_sum[g])
    );
  end

  // merge the lane sums
  always_ff @(posedge clk) begin
    logic signed [BLOCK_SUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < LANES; i++) begin
      s = s + BLOCK_SUM_W'(lane_sum[i]);
    end
    block_sum <= s;
  end

  // exact integer to fp32 conversion of the block sum
  always_ff @(posedge clk) begin
    logic [BLOCK_SUM_W-1:0] mag;
    logic [3:0]             lz;
    mag = block_sum[BLOCK_SUM_W-1] ? BLOCK_SUM_W'(-block_sum) : BLOCK_SUM_W'(block_sum);
    lz  = 4'd11;
    for (int i = 0; i < BLOCK_SUM_W - 1; i++) begin
      if (mag[i]) begin
        lz = 4'(BLOCK_SUM_W - 2 - i);
      end
    end
    if (block_sum == '0) begin
      isum_f <= 32'd0;
    end else begin
      isum_f <= round_pack(block_sum[BLOCK_SUM_W-1],
                           10'sd138 - $signed({6'b0, lz}),
                           {mag[BLOCK_SUM_W-2:0], 15'd0} << lz);
    end
  end

  // floating point chain: scale product, block term, accumulation
  always_comb begin
    m1_req.valid  = accept;
    m1_req.a      = blocks.scale_a;
    m1_req.b      = blocks.scale_b;
    m2_req.valid  = m1_rsp.valid;
    m2_req.a      = m1_rsp.res;
    m2_req.b      = isum_f;
    add_req.valid = m2_rsp.valid;
    add_req.a     = acc;
    add_req.b     = m2_rsp.res;
  end

  q4bdp_fmul u_mul_scale (.clk(clk), .rst(rst), .req(m1_req), .rsp(m1_rsp));
  q4bdp_fmul u_mul_term  (.clk(clk), .rst(rst), .req(m2_req), .rsp(m2_rsp));
  q4bdp_fadd u_add_acc   (.clk(clk), .rst(rst), .req(add_req), .rsp(add_rsp));

  // output register load
  assign out_load = last_r && can_emit
                    && ((state == S_BUSY && add_rsp.valid) || state == S_HOLD);

  // sequencer and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= 32'd0;
      out_v <= 1'b0;
    end else begin
      if (out_load) begin
        out_v <= 1'b1;
      end else if (result.ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (add_rsp.valid) begin
            if (last_r && !can_emit) begin
              state <= S_HOLD;
            end else begin
              state <= S_IDLE;
              acc   <= last_r ? 32'd0 : add_rsp.res;
            end
          end
        end
        S_HOLD: begin
          if (can_emit) begin
            state <= S_IDLE;
            acc   <= 32'd0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload held across the run; result data loaded into the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= blocks.is_last;
    end
    if (out_load) begin
      out_data <= is_nan(add_rsp.res) ? CANON_NAN : add_rsp.res;
    end
  end

  `Q4BDP_ASSERT(a_scale_to_term, m1_req.valid |-> ##3 m2_req.valid, "term multiply out of step")
  `Q4BDP_ASSERT(a_term_to_add, m2_req.valid |-> ##6 add_rsp.valid, "accumulate out of step")
  `Q4BDP_ASSERT(a_add_when_busy, add_rsp.valid |-> state == S_BUSY, "sum arrived while not busy")
  `Q4BDP_ASSERT_RST(a_reset_clear, rst |=> (acc == 32'd0 && !out_v), "reset did not clear")

endmodule
